[rtl/tlpt_pkg.sv]
package tlpt_pkg;

	// Table geometry
	localparam int ENTRIES_PER_TABLE = 512;
	localparam int TABLE_POOL        = 16;
	localparam int FRAME_BITS        = 44;

	// Fixed field widths
	localparam int VPI_W       = 18;
	localparam int FRAME_W     = 44;
	localparam int ENTRY_W     = 54;
	localparam int RAW_IDX_W   = 9;
	localparam int ENTRY_SHIFT = 10;
	localparam logic [7:0] LEAF_FLAGS = 8'hDF;  // V,R,W,X,U,A,D

	// Derived sizes
	localparam int IDX_W      = $clog2(ENTRIES_PER_TABLE);
	localparam int TBL_W      = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
	localparam int CNT_W      = $clog2(TABLE_POOL + 1);
	localparam int LEAF_DEPTH = TABLE_POOL * ENTRIES_PER_TABLE;
	localparam int LEAF_AW    = $clog2(LEAF_DEPTH);
	localparam int ROOT_W     = TBL_W + 1;
	localparam int LEAF_W     = FRAME_BITS + 1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ROOT,
		ST_LEAF,
		ST_HOLD
	} tlpt_state_t;

	// 9-bit index reduced modulo the table size: restoring compare/subtract,
	// at most eight steps, steps that can never apply drop out at elaboration.
	function automatic logic [IDX_W-1:0] ent_mod(input logic [RAW_IDX_W-1:0] v);
		logic [RAW_IDX_W-1:0] r;
		r = v;
		for (int k = 7; k >= 0; k--) begin
			if ((ENTRIES_PER_TABLE << k) < (1 << RAW_IDX_W)) begin
				if (r >= RAW_IDX_W'(ENTRIES_PER_TABLE << k))
					r = r - RAW_IDX_W'(ENTRIES_PER_TABLE << k);
			end
		end
		return r[IDX_W-1:0];
	endfunction

	function automatic logic [LEAF_AW-1:0] leaf_addr(input logic [TBL_W-1:0] t,
			input logic [IDX_W-1:0] l);
		return LEAF_AW'(t) * LEAF_AW'(ENTRIES_PER_TABLE) + LEAF_AW'(l);
	endfunction

	function automatic logic [ENTRY_W-1:0] make_entry(input logic [FRAME_BITS-1:0] f);
		return (ENTRY_W'(f) << ENTRY_SHIFT) | ENTRY_W'(LEAF_FLAGS);
	endfunction

endpackage

[rtl/tlpt_ram.sv]
module tlpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

[rtl/two_level_page_table_map_lookup.sv]
// Two-level page table, map and query of one 1 GiB region.
//
// Input channel (in_valid / in_stall): one request per item, carrying op
// (0 = map, 1 = query), the 18-bit virtual page index and, for a map, the
// frame number. Output channel (out_valid / out_stall): one result per
// request with mapped, entry_word and status.
//
// Requests are handled one at a time. A map's result is formed in ST_ROOT
// (root read, then root/leaf write); a query's in ST_LEAF (root read, then
// dependent leaf read). The two dependent reads of the synchronous root and
// leaf memories are why a query passes through ST_LEAF as well. No new
// request is taken until the previous result has left the block or been
// parked and then loaded. in_stall is low only while idle.
//
// Reset: control clears at once, then a clearing pass steps through all
// LEAF_DEPTH leaf addresses (8192 with the default geometry), zeroing the leaf
// memory and, on its first ENTRIES_PER_TABLE addresses, the root memory; no request is taken during it.
//
// A result waits in the output register while out_stall is high; the next
// request is still accepted, and its result is held internally until the
// output register frees up.
module two_level_page_table_map_lookup
	import tlpt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic [VPI_W-1:0]   virt_page_index,
	input  logic [FRAME_W-1:0] frame_page_number,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               mapped,
	output logic [ENTRY_W-1:0] entry_word,
	output logic               status
);

	tlpt_state_t state_q, state_d;

	// Request registers
	logic                  op_q;
	logic [IDX_W-1:0]      slot_q;
	logic [IDX_W-1:0]      leaf_q;
	logic [FRAME_BITS-1:0] frame_q;

	logic [CNT_W-1:0]   in_use_q;
	logic [LEAF_AW-1:0] clr_q;

	// Memory ports
	logic               root_we;
	logic [IDX_W-1:0]   root_waddr;
	logic [ROOT_W-1:0]  root_wdata;
	logic [IDX_W-1:0]   root_raddr;
	logic [ROOT_W-1:0]  root_rdata;
	logic               leaf_we;
	logic [LEAF_AW-1:0] leaf_waddr;
	logic [LEAF_W-1:0]  leaf_wdata;
	logic [LEAF_AW-1:0] leaf_raddr;
	logic [LEAF_W-1:0]  leaf_rdata;

	// Root entry as read back
	logic             root_v;
	logic [TBL_W-1:0] root_t;
	logic [TBL_W-1:0] map_tbl;
	logic             pool_empty;

	// Result of the current request
	logic                  res_valid;
	logic                  res_mapped;
	logic [FRAME_BITS-1:0] res_frame;
	logic                  res_status;
	logic                  alloc;

	// Result parked while the output register is busy
	logic                  hold_mapped_q;
	logic [FRAME_BITS-1:0] hold_frame_q;
	logic                  hold_status_q;

	logic out_free;
	logic out_load;
	logic clr_root;

	assign out_free   = !out_valid || !out_stall;
	assign root_v     = root_rdata[TBL_W];
	assign root_t     = root_rdata[TBL_W-1:0];
	assign pool_empty = (in_use_q >= CNT_W'(TABLE_POOL));
	// A fresh table is the next unused one; it was zeroed by the reset pass.
	assign map_tbl    = root_v ? root_t : in_use_q[TBL_W-1:0];
	assign root_raddr = ent_mod(virt_page_index[VPI_W-1 -: RAW_IDX_W]);
	assign leaf_raddr = leaf_addr(root_t, leaf_q);
	assign clr_root   = ({1'b0, clr_q} < (LEAF_AW+1)'(ENTRIES_PER_TABLE));

	tlpt_ram #(.WIDTH(ROOT_W), .DEPTH(ENTRIES_PER_TABLE)) u_root_ram (
		.clk   (clk),
		.we    (root_we),
		.waddr (root_waddr),
		.wdata (root_wdata),
		.raddr (root_raddr),
		.rdata (root_rdata)
	);

	tlpt_ram #(.WIDTH(LEAF_W), .DEPTH(LEAF_DEPTH)) u_leaf_ram (
		.clk   (clk),
		.we    (leaf_we),
		.waddr (leaf_waddr),
		.wdata (leaf_wdata),
		.raddr (leaf_raddr),
		.rdata (leaf_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d    = state_q;
		in_stall   = 1'b1;
		root_we    = 1'b0;
		root_waddr = clr_q[IDX_W-1:0];
		root_wdata = '0;
		leaf_we    = 1'b0;
		leaf_waddr = clr_q;
		leaf_wdata = '0;
		res_valid  = 1'b0;
		res_mapped = 1'b0;
		res_frame  = '0;
		res_status = 1'b0;
		alloc      = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				leaf_we = 1'b1;
				root_we = clr_root;
				if (clr_q == LEAF_AW'(LEAF_DEPTH - 1))
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid)
					state_d = ST_ROOT;
			end
			ST_ROOT: begin
				if (op_q) begin
					// query: empty slot answers at once
					if (root_v)
						state_d = ST_LEAF;
					else
						res_valid = 1'b1;
				end else if (!root_v && pool_empty) begin
					res_valid  = 1'b1;
					res_status = 1'b1;
				end else begin
					if (!root_v) begin
						root_we    = 1'b1;
						root_waddr = slot_q;
						root_wdata = {1'b1, map_tbl};
						alloc      = 1'b1;
					end
					leaf_we    = 1'b1;
					leaf_waddr = leaf_addr(map_tbl, leaf_q);
					leaf_wdata = {1'b1, frame_q};
					res_valid  = 1'b1;
					res_mapped = 1'b1;
					res_frame  = frame_q;
				end
			end
			ST_LEAF: begin
				res_valid  = 1'b1;
				res_mapped = leaf_rdata[FRAME_BITS];
				res_frame  = leaf_rdata[FRAME_BITS] ? leaf_rdata[FRAME_BITS-1:0] : '0;
			end
			ST_HOLD: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
		if (res_valid)
			state_d = out_free ? ST_IDLE : ST_HOLD;
	end

	assign out_load = out_free && (res_valid || (state_q == ST_HOLD));

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q  <= '0;
			clr_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (alloc)
				in_use_q <= in_use_q + CNT_W'(1);
			if (state_q == ST_CLEAR)
				clr_q <= clr_q + LEAF_AW'(1);
			if (out_load)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_q    <= op;
			slot_q  <= root_raddr;
			leaf_q  <= ent_mod(virt_page_index[RAW_IDX_W-1:0]);
			frame_q <= frame_page_number[FRAME_BITS-1:0];
		end
		if (res_valid && !out_free) begin
			hold_mapped_q <= res_mapped;
			hold_frame_q  <= res_frame;
			hold_status_q <= res_status;
		end
		if (out_load) begin
			if (res_valid) begin
				mapped     <= res_mapped;
				entry_word <= res_mapped ? make_entry(res_frame) : '0;
				status     <= res_status;
			end else begin
				mapped     <= hold_mapped_q;
				entry_word <= hold_mapped_q ? make_entry(hold_frame_q) : '0;
				status     <= hold_status_q;
			end
		end
	end

endmodule

[rtl/tlpt_checker.sv]
module tlpt_checker
	import tlpt_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic               mapped,
	input logic [ENTRY_W-1:0] entry_word,
	input logic               status
);

	// One request in flight: acceptance is followed by a stall.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted while previous one in flight");

	// Stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(entry_word) && $stable(mapped)
			&& $stable(status))
		else $error("stalled result changed");

	// Dropped map reports nothing mapped.
	a_drop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> !mapped && (entry_word == '0))
		else $error("dropped map with data");

	// A valid leaf always carries the fixed flag byte.
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mapped |-> (entry_word[7:0] == LEAF_FLAGS))
		else $error("mapped entry without leaf flags");

	// Unmapped result has a zero entry.
	a_unmapped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !mapped |-> (entry_word == '0))
		else $error("unmapped result with nonzero entry");

endmodule

bind two_level_page_table_map_lookup tlpt_checker u_tlpt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.mapped     (mapped),
	.entry_word (entry_word),
	.status     (status)
);
